// ===== design/pwl_pkg.sv =====
package pwl_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_POINTS  = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  // Fixed field widths.
  localparam int CNT_W      = 5;  // point_count register
  localparam int SLOT_W     = 4;  // point_index field
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 1'b0,
    CFG_EXTRAP_ZERO = 1'b1
  } pwl_cfg_e;

  // Input transaction kinds.
  typedef enum logic {
    ACT_QUERY = 1'b0,
    ACT_LOAD  = 1'b1
  } pwl_action_e;

  // Sequencer states of the query engine.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_LOWER,
    ST_DX,
    ST_DY,
    ST_ABS,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } pwl_state_e;

  // Status from the engine to the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } pwl_status_t;

endpackage

// ===== design/pwl_table.sv =====
module pwl_table #(
  parameter int MAX_POINTS  = pwl_pkg::DEF_MAX_POINTS,
  parameter int VALUE_WIDTH = pwl_pkg::DEF_VALUE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(MAX_POINTS)-1:0]  waddr_i,
  input  logic [VALUE_WIDTH-1:0]         wx_i,
  input  logic [VALUE_WIDTH-1:0]         wy_i,
  input  logic [$clog2(MAX_POINTS)-1:0]  raddr_i,
  output logic [VALUE_WIDTH-1:0]         rx_o,
  output logic [VALUE_WIDTH-1:0]         ry_o
);

  // Breakpoint storage; x and y share one write and one read address.
  logic [VALUE_WIDTH-1:0] x_mem [MAX_POINTS];
  logic [VALUE_WIDTH-1:0] y_mem [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      x_mem[waddr_i] <= wx_i;
      y_mem[waddr_i] <= wy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_o <= x_mem[raddr_i];
    ry_o <= y_mem[raddr_i];
  end

endmodule

// ===== design/pwl_alu.sv =====
module pwl_alu #(
  parameter int VALUE_WIDTH = pwl_pkg::DEF_VALUE_WIDTH
) (
  input  logic [VALUE_WIDTH+1:0] a_i,
  input  logic [VALUE_WIDTH+1:0] b_i,
  input  logic                   sub_i,
  output logic [VALUE_WIDTH+1:0] sum_o
);

  // Two guard bits above the value width keep every compare, difference,
  // accumulate and restoring-division step exact.
  logic [VALUE_WIDTH+1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + {{(VALUE_WIDTH+1){1'b0}}, sub_i};

endmodule

// ===== design/pwl_engine.sv =====
module pwl_engine #(
  parameter int MAX_POINTS  = pwl_pkg::DEF_MAX_POINTS,
  parameter int VALUE_WIDTH = pwl_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_WIDTH-1:0]        query_x_i,
  input  logic [pwl_pkg::CNT_W-1:0]     n_i,
  input  logic                          ext_zero_i,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr_o,
  input  logic [VALUE_WIDTH-1:0]        rd_x_i,
  input  logic [VALUE_WIDTH-1:0]        rd_y_i,
  input  logic                          slot_free_i,
  output pwl_pkg::pwl_status_t          status_o,
  output logic [VALUE_WIDTH-1:0]        result_o
);

  import pwl_pkg::*;

  localparam int W        = VALUE_WIDTH;
  localparam int IW       = $clog2(MAX_POINTS);
  localparam int CNT_BITS = $clog2(W + 1);

  pwl_state_e state_q, state_d;

  logic [W-1:0]        q_q, q_d;
  logic [W-1:0]        x0_q, x0_d;
  logic [W-1:0]        x1_q, x1_d;
  logic [W-1:0]        y0_q, y0_d;
  logic [W-1:0]        y1_q, y1_d;
  logic [W-1:0]        span_q, span_d;
  logic [W:0]          dy_q, dy_d;
  logic [W:0]          mag_q, mag_d;
  logic [2*W+1:0]      wide_q, wide_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [W-1:0]        res_q, res_d;

  logic [W+1:0] alu_a, alu_b, alu_sum;
  logic         alu_sub;
  logic         alu_neg, alu_zero;
  logic [IW-1:0] last_idx;
  logic         found;
  logic         in_range;
  logic [W-1:0] sat_val;
  logic         qbit;

  pwl_alu #(.VALUE_WIDTH(W)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign alu_neg  = alu_sum[W+1];
  assign alu_zero = (alu_sum == '0);
  assign last_idx = IW'(n_i - CNT_W'(1));
  assign found    = alu_neg || (idx_q == last_idx);
  assign qbit     = !alu_neg;

  // Saturation of the final signed sum to the value width.
  assign in_range = (&alu_sum[W+1:W-1]) || !(|alu_sum[W+1:W-1]);
  assign sat_val  = in_range ? alu_sum[W-1:0]
                  : (alu_sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (n_i == '0) ? ST_DONE : ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (n_i == CNT_W'(1) || !alu_neg) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_LAST:  state_d = alu_neg ? ST_SCAN : ST_DONE;
      ST_SCAN:  state_d = found ? ST_LOWER : ST_SCAN;
      ST_LOWER: state_d = (alu_neg || alu_zero) ? ST_DONE : ST_DX;
      ST_DX:    state_d = alu_neg ? ST_DONE : ST_DY;
      ST_DY:    state_d = ST_ABS;
      ST_ABS:   state_d = ST_MUL;
      ST_MUL:   state_d = (cnt_q == CNT_BITS'(W - 1)) ? ST_DIV : ST_MUL;
      ST_DIV:   state_d = (cnt_q == CNT_BITS'(W)) ? ST_FIN : ST_DIV;
      ST_FIN:   state_d = ST_DONE;
      ST_DONE:  state_d = slot_free_i ? ST_IDLE : ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Operand selection, table addressing and datapath updates.
  always_comb begin
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    rd_addr_o = '0;
    q_d       = q_q;
    x0_d      = x0_q;
    x1_d      = x1_q;
    y0_d      = y0_q;
    y1_d      = y1_q;
    span_d    = span_q;
    dy_d      = dy_q;
    mag_d     = mag_q;
    wide_d    = wide_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          q_d   = query_x_i;
          res_d = '0;
        end
      end
      ST_FIRST: begin
        // x[0] - q >= 0 means the query sits at or below the first point.
        alu_a     = {{2{rd_x_i[W-1]}}, rd_x_i};
        alu_b     = {{2{q_q[W-1]}}, q_q};
        alu_sub   = 1'b1;
        res_d     = (n_i == CNT_W'(1) || !ext_zero_i) ? rd_y_i : '0;
        rd_addr_o = last_idx;
      end
      ST_LAST: begin
        alu_a     = {{2{q_q[W-1]}}, q_q};
        alu_b     = {{2{rd_x_i[W-1]}}, rd_x_i};
        alu_sub   = 1'b1;
        res_d     = ext_zero_i ? '0 : rd_y_i;
        idx_d     = IW'(1);
        rd_addr_o = IW'(1);
      end
      ST_SCAN: begin
        alu_a   = {{2{q_q[W-1]}}, q_q};
        alu_b   = {{2{rd_x_i[W-1]}}, rd_x_i};
        alu_sub = 1'b1;
        if (found) begin
          x1_d      = rd_x_i;
          y1_d      = rd_y_i;
          rd_addr_o = idx_q - IW'(1);
        end else begin
          idx_d     = idx_q + IW'(1);
          rd_addr_o = idx_q + IW'(1);
        end
      end
      ST_LOWER: begin
        x0_d    = rd_x_i;
        y0_d    = rd_y_i;
        alu_a   = {{2{x1_q[W-1]}}, x1_q};
        alu_b   = {{2{rd_x_i[W-1]}}, rd_x_i};
        alu_sub = 1'b1;
        span_d  = alu_sum[W-1:0];
        res_d   = rd_y_i;
      end
      ST_DX: begin
        alu_a   = {{2{q_q[W-1]}}, q_q};
        alu_b   = {{2{x0_q[W-1]}}, x0_q};
        alu_sub = 1'b1;
        wide_d  = {{(W+2){1'b0}}, alu_sum[W-1:0]};
        res_d   = y0_q;
      end
      ST_DY: begin
        alu_a   = {{2{y1_q[W-1]}}, y1_q};
        alu_b   = {{2{y0_q[W-1]}}, y0_q};
        alu_sub = 1'b1;
        dy_d    = alu_sum[W:0];
      end
      ST_ABS: begin
        alu_a   = '0;
        alu_b   = {dy_q[W], dy_q};
        alu_sub = dy_q[W];
        mag_d   = alu_sum[W:0];
        cnt_d   = '0;
      end
      ST_MUL: begin
        // Shift-add: the multiplier dx sits in the low bits and leaves at bit 0.
        alu_a  = wide_q[2*W+1:W];
        alu_b  = wide_q[0] ? {1'b0, mag_q} : '0;
        wide_d = {1'b0, alu_sum, wide_q[W-1:1]};
        cnt_d  = (cnt_q == CNT_BITS'(W - 1)) ? '0 : cnt_q + CNT_BITS'(1);
      end
      ST_DIV: begin
        // Restoring division: the remainder stays below the span.
        alu_a   = {1'b0, wide_q[2*W:W]};
        alu_b   = {2'b00, span_q};
        alu_sub = 1'b1;
        wide_d  = {1'b0, (qbit ? alu_sum[W-1:0] : wide_q[2*W-1:W]), wide_q[W-1:0], qbit};
        cnt_d   = cnt_q + CNT_BITS'(1);
      end
      ST_FIN: begin
        alu_a   = {{2{y0_q[W-1]}}, y0_q};
        alu_b   = {1'b0, wide_q[W:0]};
        alu_sub = dy_q[W];
        res_d   = sat_val;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    y0_q   <= y0_d;
    y1_q   <= y1_d;
    span_q <= span_d;
    dy_q   <= dy_d;
    mag_q  <= mag_d;
    wide_q <= wide_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign status_o.idle      = (state_q == ST_IDLE);
  assign status_o.res_valid = (state_q == ST_DONE);
  assign result_o           = res_q;

  a_div_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (wide_q[2*W:W+1] < span_q))
    else $error("division remainder reached the span");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q != '0 && idx_q <= last_idx))
    else $error("interval scan left the populated slots");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (cnt_q < CNT_BITS'(W)))
    else $error("multiply step count overran");

endmodule

// ===== design/piecewise_linear_table_interp.sv =====
// Channel   Direction  Handshake                     Payload
// in        input      in_valid_i / in_stall_o       action_i, point_index_i, point_x_i,
//                                                     point_y_i, query_x_i
// out       output     out_valid_o / out_stall_i     result_y_o
// cfg       input      cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// A load transaction writes one breakpoint; it gives no result.
// A query transaction runs a linear scan over the table's single read port, then a
// bit-serial multiply and a restoring divide, one bit a cycle on the shared adder.
// Reset clears the sequencer, the output valid flag and both configuration registers.
// A result waiting on a stalled output does not block the next transaction.
module piecewise_linear_table_interp #(
  parameter int MAX_POINTS  = pwl_pkg::DEF_MAX_POINTS,
  parameter int VALUE_WIDTH = pwl_pkg::DEF_VALUE_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [pwl_pkg::SLOT_W-1:0]         point_index_i,
  input  logic signed [VALUE_WIDTH-1:0]      point_x_i,
  input  logic signed [VALUE_WIDTH-1:0]      point_y_i,
  input  logic signed [VALUE_WIDTH-1:0]      query_x_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]      result_y_o,

  input  logic                               cfg_we_i,
  input  logic [pwl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pwl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import pwl_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  // Configuration registers.
  logic [CNT_W-1:0] count_q, count_d;
  logic             ext_zero_q, ext_zero_d;

  // The number of points actually used is capped at the table depth.
  logic [CNT_W-1:0] n_used;

  logic in_accept;
  logic start;
  logic load_we;

  logic [IW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_x, rd_y;

  pwl_status_t            eng_status;
  logic [VALUE_WIDTH-1:0] eng_result;

  // Output register: holds one result so the engine can move on.
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] result_q, result_d;
  logic                   slot_free;

  assign n_used = (int'(count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : count_q;

  // New transactions are taken only while the engine is idle.
  assign in_stall_o = !eng_status.idle;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign start      = in_accept && (action_i == ACT_QUERY);

  // A load to a slot beyond the table depth is dropped.
  assign load_we = in_accept && (action_i == ACT_LOAD) && (int'(point_index_i) < MAX_POINTS);

  always_comb begin
    count_d    = count_q;
    ext_zero_d = ext_zero_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POINT_COUNT: count_d    = cfg_data_i[CNT_W-1:0];
        CFG_EXTRAP_ZERO: ext_zero_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ext_zero_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      ext_zero_q <= ext_zero_d;
    end
  end

  pwl_table #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (IW'(point_index_i)),
    .wx_i    (point_x_i),
    .wy_i    (point_y_i),
    .raddr_i (rd_addr),
    .rx_o    (rd_x),
    .ry_o    (rd_y)
  );

  pwl_engine #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .query_x_i   (query_x_i),
    .n_i         (n_used),
    .ext_zero_i  (ext_zero_q),
    .rd_addr_o   (rd_addr),
    .rd_x_i      (rd_x),
    .rd_y_i      (rd_y),
    .slot_free_i (slot_free),
    .status_o    (eng_status),
    .result_o    (eng_result)
  );

  // The output register can take a new result when it is empty or is being
  // drained in this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (eng_status.res_valid && slot_free) begin
      out_valid_d = 1'b1;
      result_d    = eng_result;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_y_o  = result_q;

  a_query_starts_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !eng_status.idle)
    else $error("accepted query did not start the engine");

  a_load_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && action_i == ACT_LOAD) |=> (eng_status.idle && !eng_status.res_valid))
    else $error("load transaction disturbed the engine");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eng_status.res_valid && slot_free) |=> (out_valid_o && eng_status.idle))
    else $error("finished result was not moved into the output register");

endmodule

// ===== verif/pwl_interp_checker.sv =====
// Watches the configuration port and both channels of the interpolation table,
// keeps its own copy of the breakpoints and registers, and compares every
// result transaction with the value predicted for the oldest open query.
module pwl_interp_checker #(
  parameter int VW    = pwl_pkg::DEF_VALUE_WIDTH,
  parameter int SLOTS = pwl_pkg::DEF_MAX_POINTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [pwl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pwl_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           action_i,
  input  logic [pwl_pkg::SLOT_W-1:0]     point_index_i,
  input  logic signed [VW-1:0]           point_x_i,
  input  logic signed [VW-1:0]           point_y_i,
  input  logic signed [VW-1:0]           query_x_i,

  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic signed [VW-1:0]           result_y_i,

  output int                             pending_o,
  output int                             errors_o,
  output int                             checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pwl_pkg::*;

  localparam longint SAT_HI = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic signed [VW-1:0] bp_x [SLOTS];
  logic signed [VW-1:0] bp_y [SLOTS];
  logic [CNT_W-1:0]     point_count;
  logic                 zero_outside;
  logic signed [VW-1:0] expected_y_q [$];
  logic signed [VW-1:0] want_y;
  int                   error_count = 0;
  int                   checked_count = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    error_count++;
  endtask

  // Expected output for one query against the current table and registers.
  function automatic logic signed [VW-1:0] interp_value(input logic signed [VW-1:0] qx);
    int           n;
    int           seg;
    int           i;
    bit           found;
    longint       q;
    longint       x0;
    longint       x1;
    longint       y0;
    longint       y1;
    longint       dy;
    longint       sum;
    logic [127:0] dx;
    logic [127:0] span;
    logic [127:0] mag;
    logic [127:0] quot;
    n = (point_count > SLOTS) ? SLOTS : int'(point_count);
    if (n == 0) return '0;
    if (n == 1) return bp_y[0];
    if (qx <= bp_x[0]) return zero_outside ? '0 : bp_y[0];
    if (qx >= bp_x[n-1]) return zero_outside ? '0 : bp_y[n-1];
    // The upper point of the interval is the first one above the query.
    seg   = n - 1;
    found = 1'b0;
    for (i = 1; i < n; i++) begin
      if (!found && bp_x[i] > qx) begin
        seg   = i;
        found = 1'b1;
      end
    end
    q  = qx;
    x0 = bp_x[seg-1];
    x1 = bp_x[seg];
    y0 = bp_y[seg-1];
    y1 = bp_y[seg];
    if (x1 <= x0 || q < x0) return bp_y[seg-1];
    dy   = y1 - y0;
    dx   = 128'(q - x0);
    span = 128'(x1 - x0);
    mag  = 128'((dy < 0) ? -dy : dy);
    quot = (dx * mag) / span;
    if (quot > (128'(1) << 60)) quot = 128'(1) << 60;
    sum = (dy < 0) ? y0 - longint'(quot[63:0]) : y0 + longint'(quot[63:0]);
    if (sum > SAT_HI) return VW'(SAT_HI);
    if (sum < SAT_LO) return VW'(SAT_LO);
    return VW'(sum);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bp_x[k]) begin
        bp_x[k] = '0;
        bp_y[k] = '0;
      end
      point_count  = '0;
      zero_outside = 1'b0;
      expected_y_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_y_q.size() == 0) begin
          report_mismatch($sformatf("result_y %h with no query waiting", result_y_i));
        end else begin
          want_y = expected_y_q.pop_front();
          checked_count++;
          if (result_y_i !== want_y) begin
            report_mismatch($sformatf("result_y expected %h, got %h", want_y, result_y_i));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POINT_COUNT: point_count  = cfg_data_i[CNT_W-1:0];
          CFG_EXTRAP_ZERO: zero_outside = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ACT_LOAD) begin
          if (point_index_i < SLOTS) begin
            bp_x[point_index_i] = point_x_i;
            bp_y[point_index_i] = point_y_i;
          end
        end else begin
          expected_y_q = {expected_y_q, interp_value(query_x_i)};
        end
      end
      pending_o <= expected_y_q.size();
    end
    errors_o  <= error_count;
    checked_o <= checked_count;
  end

endmodule

// ===== verif/piecewise_linear_table_interp_tb.sv =====
// Top level of the interpolation table testbench. This module only makes
// stimulus and gives the verdict; the checker beside the block does all the
// prediction and comparison and hands back its failure count.
module piecewise_linear_table_interp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwl_pkg::*;

  localparam int VW            = DEF_VALUE_WIDTH;
  localparam int SLOTS         = DEF_MAX_POINTS;
  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_PCT      = 36;
  localparam int HOLD_CYCLES   = 800;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int LIMIT_CYCLES  = 1_500_000;
  // The settle time covers the longest query (the scan plus the multiply and divide
  // passes over the value width), with a margin so a trailing load or query is surely done.
  localparam int SETTLE_CYCLES = 2 * VW + SLOTS + 9 + 32;

  localparam logic signed [VW-1:0] X_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] X_MAX = {1'b0, {(VW-1){1'b1}}};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic                   action_i      = ACT_QUERY;
  logic [SLOT_W-1:0]      point_index_i = '0;
  logic signed [VW-1:0]   point_x_i     = '0;
  logic signed [VW-1:0]   point_y_i     = '0;
  logic signed [VW-1:0]   query_x_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic signed [VW-1:0]   result_y_o;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // Status handed back by the checker.
  int pending;
  int failures;
  int checked;

  // The stimulus keeps the x positions it loaded so that it can aim queries
  // at the intervals, at the breakpoints themselves and just past either end.
  longint               tbl_x [SLOTS];

  int  queries_sent  = 0;
  int  loads_sent    = 0;
  int  settings_used = 0;
  int  random_items  = 0;
  int  cycle_count   = 0;
  // A toggle of hold_req starts one long receiver hold-off; no_idle turns
  // off random idling on both sides for a whole phase.
  bit  hold_req      = 1'b0;
  bit  no_idle       = 1'b0;

  piecewise_linear_table_interp #(
    .MAX_POINTS  (SLOTS),
    .VALUE_WIDTH (VW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .query_x_i     (query_x_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_y_o    (result_y_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  pwl_interp_checker #(
    .VW    (VW),
    .SLOTS (SLOTS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .action_i      (action_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .query_x_i     (query_x_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_y_i    (result_y_o),
    .pending_o     (pending),
    .errors_o      (failures),
    .checked_o     (checked)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A run that hangs anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one input transaction and returns at the edge that accepts it.
  // Random idle cycles come first; the payload then stays put until the
  // block lets it through. The handshake is sampled right after the edge,
  // before any of this edge's updates land, so it is what the block saw.
  task automatic send_item(input pwl_action_e act, input logic [SLOT_W-1:0] slot,
                           input logic signed [VW-1:0] px, input logic signed [VW-1:0] py,
                           input logic signed [VW-1:0] qx);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    point_index_i <= slot;
    point_x_i     <= px;
    point_y_i     <= py;
    query_x_i     <= qx;
    do @(posedge clk_i); while (in_stall_o);
    if (act == ACT_LOAD) loads_sent++;
    else queries_sent++;
  endtask

  // Fields that a query does not use carry random bits.
  task automatic send_query(input logic signed [VW-1:0] qx);
    send_item(ACT_QUERY, SLOT_W'($urandom), $urandom, $urandom, qx);
  endtask

  task automatic load_point(input logic [SLOT_W-1:0] slot, input logic signed [VW-1:0] x,
                            input logic signed [VW-1:0] y);
    send_item(ACT_LOAD, slot, x, y, $urandom);
    tbl_x[slot] = longint'(x);
  endtask

  // Stops offering, waits until every predicted result has come back, then
  // gives the block time to finish anything that produces no result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers are only written once the block is idle. The upper data bits
  // of the end-mode write carry random bits that the block must ignore.
  task automatic write_config(input int unsigned count, input bit ez);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_POINT_COUNT;
    cfg_data_i <= CFG_DATA_W'(count);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_EXTRAP_ZERO;
    cfg_data_i <= {(CFG_DATA_W-1)'($urandom), ez};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // The receiver stalls at random, stays ready through the steady phase,
  // and once holds off for a long stretch so that the block backs up.
  initial begin : result_receiver
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int                   phase;
    int                   cnt;
    int                   n;
    int                   nq;
    int                   k;
    int                   idx;
    int                   shape;
    int                   pick;
    bit                   ez;
    bit                   small_y;
    longint               step_max;
    longint               total;
    longint               start;
    longint               gap;
    longint               v;
    longint               steps [SLOTS];
    logic signed [VW-1:0] y_new;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An empty table answers zero at both extremes.
    send_query(X_MIN);
    send_query(X_MAX);
    send_query('0);
    // Extreme table: full-range x with a repeated zero, y swinging rail to rail.
    load_point(SLOT_W'(0), X_MIN, X_MAX);
    load_point(SLOT_W'(1), '0, X_MIN);
    load_point(SLOT_W'(2), '0, X_MAX);
    load_point(SLOT_W'(3), X_MAX, X_MIN);
    // A single point answers its own y for any query.
    write_config(1, 1'b0);
    send_query(VW'(32'h0001_2345));
    // Held ends, the steepest interval, and a query on the repeated x, which
    // must take the interval that starts at the second of the equal points.
    write_config(4, 1'b0);
    send_query(X_MIN);
    send_query(X_MAX);
    send_query(-1);
    send_query('0);
    send_query(1);
    send_query(VW'(32'h4000_0000));
    send_query(X_MIN + 1);
    // Same table with zero outside the ends.
    write_config(4, 1'b1);
    send_query(X_MIN);
    send_query(X_MAX);
    send_query('0);
    send_query(VW'(32'h3fff_ffff));

    // Random part, in phases. Each phase picks a setting, loads a fresh table
    // over the slots in use, then mixes queries with a little noise. The first
    // phases pin down the extremes of both registers; a count above the table
    // size must behave like a full table.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0:       begin cnt = SLOTS; ez = 1'b0; end
        1:       begin cnt = 2;     ez = 1'b1; end
        2:       begin cnt = 2;     ez = 1'b0; end
        3:       begin cnt = SLOTS; ez = 1'b1; end
        4:       begin cnt = 31;    ez = 1'b0; end
        5:       begin cnt = 0;     ez = 1'b1; end
        6:       begin cnt = 1;     ez = 1'b1; end
        default: begin
          cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS + 1, 31)
                                            : $urandom_range(0, SLOTS);
          ez  = $urandom_range(0, 1);
        end
      endcase
      write_config(cnt, ez);
      n = (cnt > SLOTS) ? SLOTS : cnt;
      // Phase 3 runs with no idling on either side.
      no_idle <= (phase == 3);

      // Table shapes: mostly ascending, with narrow, Q16-sized or wide steps
      // and some repeated x values; one shape in eight is unordered. The
      // start is placed so that the last point still fits the value range.
      shape    = $urandom_range(0, 7);
      small_y  = $urandom_range(0, 1);
      step_max = (shape <= 2) ? 255 :
                 (shape <= 5) ? (longint'(1) << 20) : ((longint'(1) << VW) / SLOTS) - 1;
      total = 0;
      for (k = 0; k < n; k++) begin
        steps[k] = (k == 0 || $urandom_range(0, 5) == 0)
                   ? 0 : longint'($urandom_range(0, step_max));
        total += steps[k];
      end
      start = longint'(X_MIN) + longint'($urandom) % ((longint'(1) << VW) - total);
      for (k = 0; k < n; k++) begin
        start += steps[k];
        v      = (shape == 0) ? longint'($signed($urandom)) : start;
        y_new  = small_y ? VW'($urandom_range(0, 1 << 20)) - VW'(1 << 19) : $urandom;
        load_point(SLOT_W'(k), VW'(v), y_new);
        random_items++;
      end

      // In phase 2 the receiver holds off while queries keep coming.
      if (phase == 2) hold_req <= ~hold_req;

      nq = $urandom_range(20, 60);
      for (k = 0; k < nq; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          // Noise: overwrite a random slot with random content.
          load_point(SLOT_W'($urandom_range(0, SLOTS - 1)), $urandom, $urandom);
        end else if (pick < 7) begin
          // The sender pauses until every open query has been answered.
          wait_idle();
        end else begin
          v = longint'($signed($urandom));
          if (n >= 2 && pick < 92) begin
            idx = $urandom_range(0, n - 2);
            if (pick < 62) begin
              gap = tbl_x[idx+1] - tbl_x[idx];
              v   = (gap > 0) ? tbl_x[idx] + longint'($urandom) % gap : tbl_x[idx];
            end else if (pick < 77) begin
              v = tbl_x[$urandom_range(0, n - 1)];
            end else if (pick < 84) begin
              v = tbl_x[0] - longint'($urandom_range(0, 65536));
            end else begin
              v = tbl_x[n-1] + longint'($urandom_range(0, 65536));
            end
          end else if (pick >= 97) begin
            v = $urandom_range(0, 1) ? longint'(X_MIN) : longint'(X_MAX);
          end
          if (v < longint'(X_MIN)) v = X_MIN;
          if (v > longint'(X_MAX)) v = X_MAX;
          send_query(VW'(v));
        end
        random_items++;
      end
      phase++;
    end

    wait_idle();
    $display("Run covered %0d queries and %0d breakpoint loads over %0d register settings,",
             queries_sent, loads_sent, settings_used);
    $display("point counts from 0 to 31 with both end modes; %0d results compared.", checked);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
